// ----- rtl/nmea_gga_field_extractor_unit_macros.svh -----
// Assertion helpers for the GGA field extractor.
// Each helper samples on clk and is disabled while arst_n is low.
`ifndef NMEA_GGA_FIELD_EXTRACTOR_UNIT_MACROS_SVH
`define NMEA_GGA_FIELD_EXTRACTOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define NGFE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("ngfe assertion failed");
`define NGFE_ASSERT_NEXT(lbl, ante, cons) \
	`NGFE_ASSERT(lbl, (ante) |=> (cons))
`else
`define NGFE_ASSERT(lbl, prop)
`define NGFE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/ngfe_pkg.sv -----
package ngfe_pkg;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic [2:0] IDENT_LEN      = 3'd5;
	localparam logic [2:0] HDR_POS_MAX    = 3'd7;
	localparam logic [3:0] COMMA_MAX      = 4'd15;
	localparam logic [3:0] COMMA_EXPECTED = 4'd14;
	localparam logic [3:0] FIELD_TIME     = 4'd1;
	localparam logic [3:0] FIELD_LAT_DIR  = 4'd3;
	localparam logic [3:0] FIELD_LON_DIR  = 4'd5;
	localparam logic [3:0] FIELD_SATS     = 4'd7;
	localparam logic [3:0] FIELD_ALT      = 4'd9;

	localparam logic KIND_FIELD  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [1:0] {
		PH_BODY,
		PH_HIGH,
		PH_LOW
	} phase_t;

	typedef struct packed {
		logic       item_kind;
		logic [3:0] field_number;
		logic [7:0] field_char;
		logic       is_default;
		logic       header_match;
		logic       comma_count_ok;
		logic       checksum_match;
		logic       sentence_valid;
	} result_t;

	// Expected identifier characters after '$': G P G G A
	function automatic logic [7:0] ident_char(input logic [2:0] pos);
		logic [7:0] ch;
		unique case (pos)
			3'd0:    ch = 8'h47;
			3'd1:    ch = 8'h50;
			3'd2:    ch = 8'h47;
			3'd3:    ch = 8'h47;
			3'd4:    ch = 8'h41;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic field_passed(input logic [3:0] f);
		return ((f >= FIELD_TIME) && (f <= FIELD_SATS)) || (f == FIELD_ALT);
	endfunction

	// Digit decode: 65 and above minus 55, else minus 48
	function automatic logic signed [8:0] hex_value(input logic [7:0] c);
		logic signed [8:0] v;
		v = (c >= 8'd65) ? ($signed({1'b0, c}) - 9'sd55) : ($signed({1'b0, c}) - 9'sd48);
		return v;
	endfunction

endpackage

// ----- rtl/ngfe_parser.sv -----
`include "nmea_gga_field_extractor_unit_macros.svh"

module ngfe_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic [7:0]       char_s1,
	output logic             has_result,
	output ngfe_pkg::result_t result
);
	import ngfe_pkg::*;

	logic              in_sentence_q, in_sentence_d;
	logic [2:0]        hdr_pos_q, hdr_pos_d;
	logic              hdr_match_q, hdr_match_d;
	logic [3:0]        comma_q, comma_d;
	logic              has_chars_q, has_chars_d;
	logic [7:0]        xor_q, xor_d;
	phase_t            phase_q, phase_d;
	logic [7:0]        high_q, high_d;

	logic              header_ok;
	logic              empty_emit;
	logic signed [8:0] hv_high;
	logic signed [8:0] hv_low;
	logic signed [12:0] rx_sum;
	logic              sum_match;

	assign header_ok  = (comma_q != 4'd0) && hdr_match_q && (hdr_pos_q == IDENT_LEN);
	assign empty_emit = header_ok && field_passed(comma_q) && (comma_q != FIELD_TIME)
		&& !has_chars_q;

	assign hv_high   = hex_value(high_q);
	assign hv_low    = hex_value(char_s1);
	assign rx_sum    = $signed({hv_high, 4'b0000}) + $signed({{4{hv_low[8]}}, hv_low});
	assign sum_match = (rx_sum == $signed({5'b00000, xor_q}));

	always_comb begin
		in_sentence_d = in_sentence_q;
		hdr_pos_d     = hdr_pos_q;
		hdr_match_d   = hdr_match_q;
		comma_d       = comma_q;
		has_chars_d   = has_chars_q;
		xor_d         = xor_q;
		phase_d       = phase_q;
		high_d        = high_q;
		has_result    = 1'b0;
		result        = '0;

		priority if (char_s1 == CH_DOLLAR) begin
			in_sentence_d = 1'b1;
			hdr_pos_d     = 3'd0;
			hdr_match_d   = 1'b1;
			comma_d       = 4'd0;
			has_chars_d   = 1'b0;
			xor_d         = 8'h00;
			phase_d       = PH_BODY;
			high_d        = 8'h00;
		end else if (!in_sentence_q) begin
			// drop characters outside a sentence
		end else if (phase_q == PH_HIGH) begin
			high_d  = char_s1;
			phase_d = PH_LOW;
		end else if (phase_q == PH_LOW) begin
			has_result            = 1'b1;
			result.item_kind      = KIND_STATUS;
			result.header_match   = header_ok;
			result.comma_count_ok = (comma_q == COMMA_EXPECTED);
			result.checksum_match = sum_match;
			result.sentence_valid = header_ok && (comma_q == COMMA_EXPECTED) && sum_match;
			in_sentence_d         = 1'b0;
			phase_d               = PH_BODY;
		end else if (char_s1 == CH_STAR) begin
			has_result          = empty_emit;
			result.field_number = comma_q;
			result.field_char   = ((comma_q == FIELD_LAT_DIR) || (comma_q == FIELD_LON_DIR))
				? CH_SPACE : CH_ZERO;
			result.is_default   = 1'b1;
			phase_d             = PH_HIGH;
		end else begin
			xor_d = xor_q ^ char_s1;
			if (char_s1 == CH_COMMA) begin
				has_result          = empty_emit;
				result.field_number = comma_q;
				result.field_char   = ((comma_q == FIELD_LAT_DIR) || (comma_q == FIELD_LON_DIR))
					? CH_SPACE : CH_ZERO;
				result.is_default   = 1'b1;
				if (comma_q < COMMA_MAX) begin
					comma_d = comma_q + 4'd1;
				end
				has_chars_d = 1'b0;
			end else if (comma_q == 4'd0) begin
				if ((hdr_pos_q >= IDENT_LEN) || (char_s1 != ident_char(hdr_pos_q))) begin
					hdr_match_d = 1'b0;
				end
				if (hdr_pos_q < HDR_POS_MAX) begin
					hdr_pos_d = hdr_pos_q + 3'd1;
				end
			end else begin
				has_chars_d         = 1'b1;
				has_result          = header_ok && field_passed(comma_q);
				result.field_number = comma_q;
				result.field_char   = char_s1;
			end
		end
		if (!has_result) begin
			result = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sentence_q <= 1'b0;
			hdr_pos_q     <= 3'd0;
			hdr_match_q   <= 1'b0;
			comma_q       <= 4'd0;
			has_chars_q   <= 1'b0;
			xor_q         <= 8'h00;
			phase_q       <= PH_BODY;
			high_q        <= 8'h00;
		end else if (adv) begin
			in_sentence_q <= in_sentence_d;
			hdr_pos_q     <= hdr_pos_d;
			hdr_match_q   <= hdr_match_d;
			comma_q       <= comma_d;
			has_chars_q   <= has_chars_d;
			xor_q         <= xor_d;
			phase_q       <= phase_d;
			high_q        <= high_d;
		end
	end

	`NGFE_ASSERT_NEXT(a_dollar_restarts, adv && (char_s1 == CH_DOLLAR), in_sentence_q && (comma_q == 4'd0) && (xor_q == 8'h00) && (phase_q == PH_BODY))
	`NGFE_ASSERT(a_phase_needs_sentence, (phase_q != PH_BODY) |-> in_sentence_q)
	`NGFE_ASSERT(a_fields_after_header, (has_result && (result.item_kind == KIND_FIELD)) |-> header_ok)

endmodule

// ----- rtl/ngfe_out_reg.sv -----
`include "nmea_gga_field_extractor_unit_macros.svh"

module ngfe_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  ngfe_pkg::result_t result,
	output logic              out_free,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              item_kind,
	output logic [3:0]        field_number,
	output logic [7:0]        field_char,
	output logic              is_default,
	output logic              header_match,
	output logic              comma_count_ok,
	output logic              checksum_match,
	output logic              sentence_valid
);
	import ngfe_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign out_free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	assign out_valid      = valid_q;
	assign item_kind      = data_q.item_kind;
	assign field_number   = data_q.field_number;
	assign field_char     = data_q.field_char;
	assign is_default     = data_q.is_default;
	assign header_match   = data_q.header_match;
	assign comma_count_ok = data_q.comma_count_ok;
	assign checksum_match = data_q.checksum_match;
	assign sentence_valid = data_q.sentence_valid;

	`NGFE_ASSERT(a_status_clean, (valid_q && (data_q.item_kind == KIND_STATUS)) |-> ((data_q.field_number == 4'd0) && (data_q.field_char == 8'h00) && !data_q.is_default))
	`NGFE_ASSERT(a_field_number_passed, (valid_q && (data_q.item_kind == KIND_FIELD)) |-> (((data_q.field_number >= FIELD_TIME) && (data_q.field_number <= FIELD_SATS)) || (data_q.field_number == FIELD_ALT)))
	`NGFE_ASSERT(a_load_only_when_free, load |-> out_free)

endmodule

// ----- rtl/nmea_gga_field_extractor_unit.sv -----
// GGA sentence field extractor: one received character per transfer.
// Path: each character's input transfer loads the input register; parse logic
// then writes its result into the result register.
// Throughput: one character per cycle while the output side is not stalled;
// a character that yields no result never waits on the output side.
// Reset: arst_n clears the sentence tracker and both valid flags at once.

module nmea_gga_field_extractor_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       item_kind,
	output logic [3:0] field_number,
	output logic [7:0] field_char,
	output logic       is_default,
	output logic       header_match,
	output logic       comma_count_ok,
	output logic       checksum_match,
	output logic       sentence_valid
);
	import ngfe_pkg::*;

	// Input register stage
	logic       valid_s1;
	logic [7:0] char_s1;

	// Parse and output hand-off
	logic    has_result;
	result_t result;
	logic    out_free;
	logic    adv;
	logic    load;

	// Advance the held character when it yields nothing, or when the result
	// register can take its result this cycle.
	assign adv      = valid_s1 && (!has_result || out_free);
	assign load     = valid_s1 && has_result && out_free;
	// Hold the input side only while a character is stuck in stage one.
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= rx_char;
		end
	end

	// Sentence tracker: header check, comma count, XOR and checksum decode
	ngfe_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.char_s1    (char_s1),
		.has_result (has_result),
		.result     (result)
	);

	// Result register toward the consumer
	ngfe_out_reg u_out_reg (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (load),
		.result         (result),
		.out_free       (out_free),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.item_kind      (item_kind),
		.field_number   (field_number),
		.field_char     (field_char),
		.is_default     (is_default),
		.header_match   (header_match),
		.comma_count_ok (comma_count_ok),
		.checksum_match (checksum_match),
		.sentence_valid (sentence_valid)
	);

endmodule

// ----- verif/tb_nmea_gga_field_extractor_unit.sv -----
module tb_nmea_gga_field_extractor_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ngfe_pkg::*;

	// Random stimulus stops once this many sentence characters have been sent
	localparam int RANDOM_ITEMS = 1900;
	// Worst case is roughly 2200 characters, each behind the longest input gap and
	// the longest output stall; the limit leaves plenty of margin over that
	localparam int unsigned CYCLE_LIMIT = 800000;
	// Results pass the input register and then the result register; drain a little longer
	localparam int DRAIN_CYCLES = 16;
	// Only the first mismatches get a line of their own
	localparam int PRINT_LIMIT = 40;

	// Identifier after the dollar sign
	localparam logic [7:0] GGA_ID [5] = '{"G", "P", "G", "G", "A"};

	typedef struct {
		logic [7:0] ch;
		logic       typed;
		result_t    want;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] rx_char;
	logic       out_valid;
	logic       out_stall;
	logic       item_kind;
	logic [3:0] field_number;
	logic [7:0] field_char;
	logic       is_default;
	logic       header_match;
	logic       comma_count_ok;
	logic       checksum_match;
	logic       sentence_valid;

	// Parser state mirrored by the predictor
	logic       in_msg;
	logic [2:0] id_pos;
	logic       id_ok;
	logic [3:0] commas;
	logic       field_seen;
	logic [7:0] xor_sum;
	phase_t     cks_phase;
	logic [7:0] cks_hi;

	result_t     awaited_items [$];
	logic [7:0]  line_bytes [$];
	int          errors;
	int          sent_items;
	int unsigned cycles;
	int          in_calm;
	int          out_calm;

	nmea_gga_field_extractor_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_char        (rx_char),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.item_kind      (item_kind),
		.field_number   (field_number),
		.field_char     (field_char),
		.is_default     (is_default),
		.header_match   (header_match),
		.comma_count_ok (comma_count_ok),
		.checksum_match (checksum_match),
		.sentence_valid (sentence_valid)
	);

	// Start low so the first rising edge comes after every process is set up
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Hard stop in case the handshake hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_nmea_gga_field_extractor_unit failed");
			$finish;
		end
	end

	// Substitute character emitted when field f closes empty
	function automatic result_t sub_char(input logic [3:0] f, input logic [7:0] ch);
		result_t r;
		r = '0;
		r.item_kind = KIND_FIELD;
		r.field_number = f;
		r.field_char = ch;
		r.is_default = 1'b1;
		return r;
	endfunction

	function automatic result_t status_of(input logic h, input logic k, input logic x);
		result_t r;
		r = '0;
		r.item_kind = KIND_STATUS;
		r.header_match = h;
		r.comma_count_ok = k;
		r.checksum_match = x;
		r.sentence_valid = h & k & x;
		return r;
	endfunction

	// Fields forwarded downstream: time through satellites, plus altitude
	function automatic logic is_carried(input logic [3:0] f);
		return (f != 4'd0) && ((f <= FIELD_SATS) || (f == FIELD_ALT));
	endfunction

	// Checksum digits decode the loose way: letters from 'A' up minus 55,
	// everything else minus 48, so junk simply yields an odd value
	function automatic int digit_val(input logic [7:0] c);
		return int'(c) - ((c >= 8'd65) ? 55 : 48);
	endfunction

	// Closing a field (comma or star): an empty carried field other than time
	// yields its default character
	function automatic logic empty_field(input logic hdr, output result_t r);
		r = '0;
		if (hdr && is_carried(commas) && (commas != FIELD_TIME) && !field_seen) begin
			r = sub_char(commas,
				((commas == FIELD_LAT_DIR) || (commas == FIELD_LON_DIR)) ? CH_SPACE : CH_ZERO);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advance the predicted parser by one accepted character; return 1 and the
	// expected item when the character produces one
	function automatic logic parse_char(input logic [7:0] c, output result_t r);
		logic hdr;
		logic got;
		r = '0;
		hdr = (commas != 4'd0) && id_ok && (id_pos == IDENT_LEN);
		if (c == CH_DOLLAR) begin
			in_msg = 1'b1;
			id_pos = '0;
			id_ok = 1'b1;
			commas = '0;
			field_seen = 1'b0;
			xor_sum = '0;
			cks_phase = PH_BODY;
			cks_hi = '0;
			return 1'b0;
		end
		if (!in_msg)
			return 1'b0;
		// After the star, anything at all is taken as a checksum digit
		case (cks_phase)
			PH_HIGH: begin
				cks_hi = c;
				cks_phase = PH_LOW;
				return 1'b0;
			end
			PH_LOW: begin
				r = status_of(hdr, commas == COMMA_EXPECTED,
					16 * digit_val(cks_hi) + digit_val(c) == int'(xor_sum));
				in_msg = 1'b0;
				cks_phase = PH_BODY;
				return 1'b1;
			end
			default: ;
		endcase
		if (c == CH_STAR) begin
			cks_phase = PH_HIGH;
			return empty_field(hdr, r);
		end
		xor_sum = xor_sum ^ c;
		if (c == CH_COMMA) begin
			got = empty_field(hdr, r);
			if (commas != COMMA_MAX)
				commas = commas + 4'd1;
			field_seen = 1'b0;
			return got;
		end
		if (commas == 4'd0) begin
			if ((id_pos >= IDENT_LEN) || (c != GGA_ID[id_pos]))
				id_ok = 1'b0;
			if (id_pos != HDR_POS_MAX)
				id_pos = id_pos + 3'd1;
			return 1'b0;
		end
		field_seen = 1'b1;
		if (hdr && is_carried(commas)) begin
			r.item_kind = KIND_FIELD;
			r.field_number = commas;
			r.field_char = c;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Idle length for one side: mostly none or short, now and then long, and
	// occasional calm stretches with no idling at all
	function automatic int pick_idle(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 120);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(13, 40);
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		return (n < 4'd10) ? CH_ZERO + 8'(n) : 8'h37 + 8'(n);
	endfunction

	// Field text: mostly digits, dots and capitals, some raw bytes of any value
	// except the three separators
	function automatic logic [7:0] field_byte();
		logic [7:0] c;
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return CH_ZERO + 8'($urandom_range(0, 9));
		if (r < 60)
			return ".";
		if (r < 80)
			return 8'h41 + 8'($urandom_range(0, 25));
		do
			c = 8'($urandom_range(0, 255));
		while ((c == CH_DOLLAR) || (c == CH_COMMA) || (c == CH_STAR));
		return c;
	endfunction

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("%0t ns: %s got %0h expected %0h", $time, what, got, want);
	endtask

	// Build one sentence into line_bytes: mostly well-formed $GPGGA with random
	// content, the rest with a broken identifier, wrong comma count, no comma,
	// cut short, or junk after the star; some checksums are also wrong or junk
	task automatic compose_sentence();
		logic [7:0] id [$];
		logic [7:0] sum;
		logic [7:0] ch;
		int mode;
		int ncomma;
		int flen;
		int cut;
		int k;
		int j;
		line_bytes.delete();
		foreach (GGA_ID[i])
			id.push_back(GGA_ID[i]);
		mode = $urandom_range(0, 99);
		ncomma = 14;
		if (mode >= 62 && mode < 70) begin
			ncomma = $urandom_range(11, 17);
		end else if (mode >= 70 && mode < 78) begin
			case ($urandom_range(0, 2))
				0: void'(id.pop_back());
				1: id.push_back(field_byte());
				default: id[$urandom_range(0, 4)] = field_byte();
			endcase
		end else if (mode >= 78 && mode < 83) begin
			ncomma = 0;
		end
		line_bytes.push_back(CH_DOLLAR);
		sum = '0;
		foreach (id[i]) begin
			line_bytes.push_back(id[i]);
			sum = sum ^ id[i];
		end
		for (k = 0; k < ncomma; k++) begin
			line_bytes.push_back(CH_COMMA);
			sum = sum ^ CH_COMMA;
			flen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			for (j = 0; j < flen; j++) begin
				ch = field_byte();
				line_bytes.push_back(ch);
				sum = sum ^ ch;
			end
		end
		// Cut short without a star: the next dollar restarts mid-sentence
		if (mode >= 83 && mode < 90) begin
			cut = $urandom_range(1, line_bytes.size() - 1);
			line_bytes = line_bytes[0:cut-1];
			return;
		end
		line_bytes.push_back(CH_STAR);
		if (mode >= 90) begin
			repeat (2) begin
				case ($urandom_range(0, 3))
					0: line_bytes.push_back(CH_COMMA);
					1: line_bytes.push_back(CH_STAR);
					2: line_bytes.push_back(CH_DOLLAR);
					default: line_bytes.push_back(8'($urandom_range(0, 255)));
				endcase
			end
		end else if ($urandom_range(0, 9) < 8) begin
			line_bytes.push_back(hex_digit(sum[7:4]));
			line_bytes.push_back(hex_digit(sum[3:0]));
		end else if ($urandom_range(0, 1) == 0) begin
			sum = sum ^ 8'($urandom_range(1, 255));
			line_bytes.push_back(hex_digit(sum[7:4]));
			line_bytes.push_back(hex_digit(sum[3:0]));
		end else begin
			line_bytes.push_back(8'($urandom_range(0, 255)));
			line_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// Offer one character and hold it until the transfer; a typed row supplies
	// its own expectation, otherwise the predictor's result is queued
	task automatic send_char(input logic [7:0] c, input logic typed, input result_t want);
		result_t r;
		logic got;
		int gap;
		gap = pick_idle(in_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_char <= c;
		do
			@(posedge clk);
		while (in_stall);
		got = parse_char(c, r);
		if (typed)
			awaited_items.push_back(want);
		else if (got)
			awaited_items.push_back(r);
	endtask

	// Compare one result transfer with the oldest expectation
	task automatic check_result();
		result_t want;
		if (awaited_items.size() == 0) begin
			report("unexpected result, field_char", field_char, 8'h00);
			return;
		end
		want = awaited_items.pop_front();
		if (item_kind !== want.item_kind)
			report("item_kind", item_kind, want.item_kind);
		if (field_number !== want.field_number)
			report("field_number", field_number, want.field_number);
		if (field_char !== want.field_char)
			report("field_char", field_char, want.field_char);
		if (is_default !== want.is_default)
			report("is_default", is_default, want.is_default);
		if (header_match !== want.header_match)
			report("header_match", header_match, want.header_match);
		if (comma_count_ok !== want.comma_count_ok)
			report("comma_count_ok", comma_count_ok, want.comma_count_ok);
		if (checksum_match !== want.checksum_match)
			report("checksum_match", checksum_match, want.checksum_match);
		if (sentence_valid !== want.sentence_valid)
			report("sentence_valid", sentence_valid, want.sentence_valid);
	endtask

	// Output side: check each transfer, then pick the stall for the next edge.
	// Values read right after the edge are the ones the edge sampled.
	initial begin
		int stall_left;
		int n;
		stall_left = 0;
		out_calm = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				check_result();
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				n = pick_idle(out_calm);
				out_stall <= (n > 0);
				if (n > 0)
					stall_left = n - 1;
			end
		end
	end

	initial begin
		stim_row_t rows [$];
		result_t none;
		logic [7:0] ch;
		int n;
		none = '0;
		errors = 0;
		sent_items = 0;
		cycles = 0;
		in_calm = 0;
		in_msg = 1'b0;
		id_pos = '0;
		id_ok = 1'b0;
		commas = '0;
		field_seen = 1'b0;
		xor_sum = '0;
		cks_phase = PH_BODY;
		cks_hi = '0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		rx_char <= '0;

		// Directed sentence: byte extremes ignored outside a sentence, a dollar
		// restarting a half-read identifier, then a minimal $GPGGA with all
		// fourteen fields empty. Each closing comma of a carried field yields its
		// default; the empty time field yields nothing. The body XORs to 0x56.
		rows = '{
			'{8'h00,     1'b0, none},
			'{8'hFF,     1'b0, none},
			'{CH_DOLLAR, 1'b0, none},
			'{"G",       1'b0, none},
			'{CH_DOLLAR, 1'b0, none},
			'{"G",       1'b0, none},
			'{"P",       1'b0, none},
			'{"G",       1'b0, none},
			'{"G",       1'b0, none},
			'{"A",       1'b0, none},
			'{CH_COMMA,  1'b0, none},
			'{CH_COMMA,  1'b0, none},
			'{CH_COMMA,  1'b1, sub_char(4'd2, CH_ZERO)},
			'{CH_COMMA,  1'b1, sub_char(FIELD_LAT_DIR, CH_SPACE)},
			'{CH_COMMA,  1'b1, sub_char(4'd4, CH_ZERO)},
			'{CH_COMMA,  1'b1, sub_char(FIELD_LON_DIR, CH_SPACE)},
			'{CH_COMMA,  1'b1, sub_char(4'd6, CH_ZERO)},
			'{CH_COMMA,  1'b1, sub_char(FIELD_SATS, CH_ZERO)},
			'{CH_COMMA,  1'b0, none},
			'{CH_COMMA,  1'b1, sub_char(FIELD_ALT, CH_ZERO)},
			'{CH_COMMA,  1'b0, none},
			'{CH_COMMA,  1'b0, none},
			'{CH_COMMA,  1'b0, none},
			'{CH_COMMA,  1'b0, none},
			'{CH_STAR,   1'b0, none},
			'{"5",       1'b0, none},
			'{"6",       1'b1, status_of(1'b1, 1'b1, 1'b1)}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (rows[i])
			send_char(rows[i].ch, rows[i].typed, rows[i].want);

		// Random sentences, with stray bytes dropped in between now and then;
		// the stray bytes are not counted toward the stimulus total
		while (sent_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 6) == 0) begin
				n = $urandom_range(1, 6);
				repeat (n) begin
					do
						ch = 8'($urandom_range(0, 255));
					while (ch == CH_DOLLAR);
					send_char(ch, 1'b0, none);
				end
			end
			compose_sentence();
			foreach (line_bytes[i])
				send_char(line_bytes[i], 1'b0, none);
			sent_items += line_bytes.size();
		end
		in_valid <= 1'b0;

		// Drain, then keep watching for a while to catch stray results
		while (awaited_items.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("tb_nmea_gga_field_extractor_unit passed");
		else
			$display("tb_nmea_gga_field_extractor_unit failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ngfe_pkg.sv
rtl/ngfe_parser.sv
rtl/ngfe_out_reg.sv
rtl/nmea_gga_field_extractor_unit.sv
verif/tb_nmea_gga_field_extractor_unit.sv
